// ===== hdl/gsph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gsph_pkg;

  localparam int NUM_SEQS    = 4;
  localparam int COUNT_WIDTH = 32;

  localparam int CHAR_W      = 8;
  localparam int CODE_W      = 4;
  localparam int IDX_W       = 16;
  localparam int OUT_COUNT_W = 32;
  localparam int STORE_DEPTH = 1 << IDX_W;

  // result queue
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int OCC_W       = PTR_W + 1;

  // genotype codes in sorted text order
  localparam logic [CODE_W-1:0] GT_AA = 4'd0;
  localparam logic [CODE_W-1:0] GT_AC = 4'd1;
  localparam logic [CODE_W-1:0] GT_AG = 4'd2;
  localparam logic [CODE_W-1:0] GT_AT = 4'd3;
  localparam logic [CODE_W-1:0] GT_CC = 4'd4;
  localparam logic [CODE_W-1:0] GT_CG = 4'd5;
  localparam logic [CODE_W-1:0] GT_CT = 4'd6;
  localparam logic [CODE_W-1:0] GT_GG = 4'd7;
  localparam logic [CODE_W-1:0] GT_GT = 4'd8;
  localparam logic [CODE_W-1:0] GT_NN = 4'd9;
  localparam logic [CODE_W-1:0] GT_TT = 4'd10;

  localparam logic ACT_TALLY = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] base_0;
    logic [CHAR_W-1:0] base_1;
    logic [CHAR_W-1:0] base_2;
    logic [CHAR_W-1:0] base_3;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]       pattern_index;
    logic [OUT_COUNT_W-1:0] count;
  } out_item_t;

  function automatic logic [CODE_W-1:0] genotype_code(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] code;
    case (ch)
      "A", "a": code = GT_AA;
      "M", "m": code = GT_AC;
      "R", "r": code = GT_AG;
      "W", "w": code = GT_AT;
      "C", "c": code = GT_CC;
      "S", "s": code = GT_CG;
      "Y", "y": code = GT_CT;
      "G", "g": code = GT_GG;
      "K", "k": code = GT_GT;
      "T", "t": code = GT_TT;
      default:  code = GT_NN;
    endcase
    return code;
  endfunction

  // wide counters report as all ones once past the output field
  function automatic logic [OUT_COUNT_W-1:0] clip_count(input count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    if (wide > 64'(32'hFFFF_FFFF)) begin
      return '1;
    end
    return wide[OUT_COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gsph_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gsph_in_if import gsph_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gsph_out_if import gsph_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/genotype_site_pattern_histogram_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Site pattern histogram: a tally item maps each sequence's IUPAC character to a
// genotype code, joins the codes into a 16-bit pattern index and adds one to the
// saturating counter kept there; a read item returns the count at read_index.
// One item is taken per cycle. The counters sit in a single 65536-entry memory
// with a registered read; a tally reads in the cycle it is taken and writes back
// in the next, and the last write is forwarded so back-to-back hits on one
// counter stay exact. Read results leave through a four-entry queue, and input
// stalls when that queue would overflow and during clearing. After reset every
// memory entry is zeroed in a clearing pass, during which no item is taken.
module genotype_site_pattern_histogram_unit import gsph_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  gsph_in_if.sink     req,
  gsph_out_if.source  rsp
);

  // counter store
  count_t             store [STORE_DEPTH];
  count_t             rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  count_t             mem_wdata;

  // clearing pass
  logic               clearing;
  logic [IDX_W-1:0]   clr_addr;

  // read-back stage
  logic               s1_valid;
  logic               s1_action;
  logic [IDX_W-1:0]   s1_addr;

  // last tally write, for forwarding
  logic               wr_valid;
  logic [IDX_W-1:0]   wr_addr;
  count_t             wr_data;

  // result queue
  out_item_t          fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [OCC_W-1:0]   occ;

  logic               accept;
  logic [IDX_W-1:0]   site_idx;
  logic [CHAR_W-1:0]  bases [4];
  count_t             cur;
  count_t             bumped;
  logic               s1_tally;
  logic               s1_read;
  logic               push;
  logic               pop;

  assign bases[0] = req.data.base_0;
  assign bases[1] = req.data.base_1;
  assign bases[2] = req.data.base_2;
  assign bases[3] = req.data.base_3;

  always_comb begin
    site_idx = '0;
    for (int s = 0; s < NUM_SEQS; s++) begin
      site_idx[CODE_W*(NUM_SEQS-1-s) +: CODE_W] = genotype_code(bases[s]);
    end
  end

  assign s1_tally = s1_valid && (s1_action == ACT_TALLY);
  assign s1_read  = s1_valid && (s1_action == ACT_READ);

  // leave room for a read still in the read-back stage
  assign req.ready = !clearing &&
                     ((occ + OCC_W'(s1_read)) < OCC_W'(FIFO_DEPTH));
  assign accept    = req.valid && req.ready;
  assign rd_addr   = (req.data.action == ACT_READ) ? req.data.read_index : site_idx;

  assign cur    = (wr_valid && (wr_addr == s1_addr)) ? wr_data : rd_data;
  assign bumped = (cur == '1) ? cur : cur + count_t'(1);

  assign mem_we    = clearing || s1_tally;
  assign mem_waddr = clearing ? clr_addr : s1_addr;
  assign mem_wdata = clearing ? '0 : bumped;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      wr_valid <= s1_tally;
    end
    s1_action <= req.data.action;
    s1_addr   <= rd_addr;
    wr_addr   <= s1_addr;
    wr_data   <= bumped;
  end

  assign push = s1_read;
  assign pop  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      occ <= occ + OCC_W'(push) - OCC_W'(pop);
    end
    if (push) begin
      fifo[wr_ptr] <= '{pattern_index: s1_addr, count: clip_count(cur)};
    end
  end

  assign rsp.valid = (occ != '0);
  assign rsp.data  = fifo[rd_ptr];

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("item taken during clearing pass");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_read_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    s1_read |=> rsp.valid)
    else $error("read result not queued");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == '1)
    else $error("clearing pass ended early");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gsph_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RUN_LIMIT_NS = 10_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 100;

  // letters in code order, upper case; lower case differs only in bit 5
  localparam logic [CHAR_W-1:0] IUPAC [10] = '{"A", "M", "R", "W", "C", "S", "Y", "G", "K", "T"};
  localparam logic [CODE_W-1:0] IUPAC_CODE [10] = '{GT_AA, GT_AC, GT_AG, GT_AT, GT_CC,
                                                    GT_CG, GT_CT, GT_GG, GT_GT, GT_TT};

  logic clk = 1'b0;
  logic rst = 1'b1;

  gsph_in_if  req_if ();
  gsph_out_if rsp_if ();

  genotype_site_pattern_histogram_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #CLK_HALF clk = ~clk;

  count_t           site_tally [STORE_DEPTH];
  out_item_t        pending_counts [$];
  logic [IDX_W-1:0] seen_patterns [$];
  int               fails = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               rsp_hold = 0;

  initial begin
    foreach (site_tally[i]) site_tally[i] = '0;
  end

  function automatic logic [CODE_W-1:0] code_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] up;
    logic [CODE_W-1:0] code;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    code = GT_NN;
    for (int i = 0; i < 10; i++) begin
      if (IUPAC[i] == up) code = IUPAC_CODE[i];
    end
    return code;
  endfunction

  function automatic logic [IDX_W-1:0] site_index(input in_item_t it);
    logic [CHAR_W-1:0] bases [4];
    logic [IDX_W-1:0]  idx;
    bases = '{it.base_0, it.base_1, it.base_2, it.base_3};
    idx = '0;
    for (int s = 0; s < NUM_SEQS; s++) idx = (idx << CODE_W) | IDX_W'(code_of(bases[s]));
    return idx;
  endfunction

  // bring the histogram up to date for an accepted item, queue what a read returns
  function automatic void apply_item(input in_item_t it);
    logic [IDX_W-1:0] idx;
    out_item_t        r;
    if (it.action == ACT_TALLY) begin
      idx = site_index(it);
      if (site_tally[idx] != '1) site_tally[idx] = site_tally[idx] + count_t'(1);
      seen_patterns.insert(seen_patterns.size(), idx);
    end else begin
      r.pattern_index = it.read_index;
      if (64'(site_tally[it.read_index]) > 64'hFFFF_FFFF) r.count = '1;
      else r.count = OUT_COUNT_W'(site_tally[it.read_index]);
      pending_counts.insert(pending_counts.size(), r);
    end
  endfunction

  function automatic in_item_t mk_tally(input logic [CHAR_W-1:0] b0, b1, b2, b3);
    in_item_t it;
    it.action     = ACT_TALLY;
    it.base_0     = b0;
    it.base_1     = b1;
    it.base_2     = b2;
    it.base_3     = b3;
    it.read_index = IDX_W'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic in_item_t mk_read(input logic [IDX_W-1:0] idx);
    in_item_t it;
    it.action     = ACT_READ;
    it.base_0     = CHAR_W'($urandom_range(0, 255));
    it.base_1     = CHAR_W'($urandom_range(0, 255));
    it.base_2     = CHAR_W'($urandom_range(0, 255));
    it.base_3     = CHAR_W'($urandom_range(0, 255));
    it.read_index = idx;
    return it;
  endfunction

  function automatic logic [CHAR_W-1:0] any_base();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return IUPAC[$urandom_range(0, 9)] | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    if (pick < 70) begin
      case ($urandom_range(0, 2))
        0:       return "-";
        1:       return "N";
        default: return "n";
      endcase
    end
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t rand_tally_item();
    return mk_tally(any_base(), any_base(), any_base(), any_base());
  endfunction

  function automatic in_item_t rand_read();
    logic [IDX_W-1:0] idx;
    int               pick;
    idx = '0;
    pick = $urandom_range(0, 99);
    if (pick < 60 && seen_patterns.size() > 0) begin
      idx = seen_patterns[$urandom_range(0, seen_patterns.size() - 1)];
    end else if (pick < 80) begin
      idx = IDX_W'($urandom_range(0, 65535));
    end else begin
      for (int s = 0; s < 4; s++) begin
        idx = {idx[IDX_W-CODE_W-1:0], CODE_W'($urandom_range(0, GT_TT))};
      end
    end
    return mk_read(idx);
  endfunction

  task automatic send_item(input in_item_t it);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (!req_if.ready);
    apply_item(it);
  endtask

  // always waits for a clock edge, so valid is never lowered and raised in one step
  task automatic wait_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  task automatic test_codes();
    for (int i = 0; i < 10; i++) begin
      send_item(mk_tally(IUPAC[i], IUPAC[i] | 8'h20, IUPAC[i], IUPAC[i] | 8'h20));
    end
    // gap, unknown and non-letter bytes all land on NN
    send_item(mk_tally("-", "N", 8'h00, 8'hFF));
    // same counter twice in a row, then read straight after
    send_item(mk_tally("A", "c", "G", "t"));
    send_item(mk_tally("a", "C", "g", "T"));
    send_item(mk_read({GT_AA, GT_CC, GT_GG, GT_TT}));
    send_item(mk_read({4{GT_AA}}));
    send_item(mk_read({4{GT_TT}}));
    send_item(mk_read({4{GT_NN}}));
    send_item(mk_read({4{GT_GT}}));
    send_item(mk_read({4{GT_CT}}));
    // indices no site can reach
    send_item(mk_read(16'hFFFF));
    send_item(mk_read(16'hB000));
    wait_results();
  endtask

  task automatic test_random_mix(input int n);
    in_item_t last_tally;
    in_item_t it;
    last_tally = rand_tally_item();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 62) begin
        // some tallies repeat the previous site to hit the write-back forwarding
        if ($urandom_range(0, 4) != 0) last_tally = rand_tally_item();
        it = last_tally;
      end else begin
        it = rand_read();
      end
      send_item(it);
    end
    wait_results();
  endtask

  task automatic test_backpressure();
    for (int k = 0; k < 10; k++) send_item(rand_tally_item());
    rsp_hold <= HOLD_CYCLES;
    for (int k = 0; k < 40; k++) send_item(rand_read());
    // sender holds off until every read has come back
    wait_results();
    for (int k = 0; k < 20; k++) begin
      send_item(($urandom_range(0, 1) != 0) ? rand_read() : rand_tally_item());
    end
    wait_results();
  endtask

  always @(posedge clk) begin
    if (rsp_hold > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold     <= rsp_hold - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_counts
    out_item_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_counts.size() == 0) begin
        $error("count with nothing pending: pattern_index %h count %0d",
               rsp_if.data.pattern_index, rsp_if.data.count);
        fails++;
      end else begin
        want = pending_counts.pop_front();
        if (rsp_if.data.pattern_index !== want.pattern_index) begin
          $error("pattern_index: expected %h, got %h", want.pattern_index,
                 rsp_if.data.pattern_index);
          fails++;
        end
        if (rsp_if.data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_if.data.count);
          fails++;
        end
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_codes();
    send_idle_pct = 19;
    recv_idle_pct = 76;
    test_random_mix(330);
    send_idle_pct = 76;
    recv_idle_pct = 19;
    test_random_mix(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(330);
    test_backpressure();

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // covers the clearing pass after reset with a wide margin
  initial begin
    #RUN_LIMIT_NS;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gsph_pkg.sv
hdl/gsph_if.sv
hdl/genotype_site_pattern_histogram_unit.sv
tb/sv/tb.sv
